[src/qmask_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmask_pkg
// Shared widths, item types and cross-product bookkeeping for the
// quadrilateral mask pixel selector.
// ----------------------------------------------------------------------------
package qmask_pkg;

  // Coordinate and color widths
  localparam int COORD_BITS   = 12;
  localparam int COLOR_BITS   = 8;
  localparam int NUM_CORNERS  = 4;
  localparam int CORNER_IDX_W = $clog2(NUM_CORNERS);
  localparam int CFG_IDX_W    = CORNER_IDX_W + 1;

  // Datapath widths: corner minus pixel, products, cross products
  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int CROSS_W = PROD_W + 1;

  // Configuration index: low bit selects the axis, upper bits the corner
  localparam logic AXIS_X = 1'b0;
  localparam logic AXIS_Y = 1'b1;

  // Edge cross products cross(d[a], d[b]) with d[i] = corner i - pixel
  localparam int NUM_CROSS = 5;
  localparam int CR_01 = 0;
  localparam int CR_12 = 1;
  localparam int CR_20 = 2;
  localparam int CR_23 = 3;
  localparam int CR_30 = 4;
  localparam int CROSS_A [NUM_CROSS] = '{0, 1, 2, 2, 3};
  localparam int CROSS_B [NUM_CROSS] = '{1, 2, 0, 3, 0};

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [COLOR_BITS-1:0] color_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } corner_t;

  typedef corner_t [NUM_CORNERS-1:0] corner_arr_t;

  typedef struct packed {
    color_t blue;
    color_t green;
    color_t red;
  } rgb_t;

  typedef struct packed {
    rgb_t fore;
    rgb_t back;
  } color_pair_t;

  typedef struct packed {
    logic [NUM_CROSS-1:0] pos;
    logic [NUM_CROSS-1:0] neg;
  } sign_flags_t;

  typedef struct packed {
    coord_t pixel_col;
    coord_t pixel_row;
    color_t fore_blue;
    color_t fore_green;
    color_t fore_red;
    color_t back_blue;
    color_t back_green;
    color_t back_red;
  } in_item_t;

  typedef struct packed {
    color_t out_blue;
    color_t out_green;
    color_t out_red;
    logic   inside_quad;
  } out_item_t;

endpackage

[src/quad_mask_pixel_select.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_mask_pixel_select
// Passes the foreground pixel where the coordinate lies inside a configured
// quadrilateral (boundary included), the background pixel elsewhere.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration: write corner coordinates through cfg_we / cfg_index /
//   cfg_data (index 0..7 = corner0 x,y .. corner3 x,y) while no item is in
//   flight; a write takes effect at the next edge.
//   Input: an item is accepted at each edge with start high and busy low.
//   busy stays low, so one item can be accepted every clock cycle.
//   Output: each result appears on out_data for one cycle with out_valid
//   high, once it has passed the register stages below, in acceptance order.
//   Results pass through four register stages: corner offsets, partial
//   products, cross-product signs, triangle test and color select.
//   Throughput is one item per cycle; the receiver cannot stall and every
//   result must be taken in the cycle it is shown.
//   Reset (rst_n low, synchronous) clears all corners to zero and drops any
//   items in flight.
// ----------------------------------------------------------------------------
module quad_mask_pixel_select (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  qmask_pkg::in_item_t               in_data,
  output logic                              out_valid,
  output qmask_pkg::out_item_t              out_data,
  input  logic                              cfg_we,
  input  logic [qmask_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [qmask_pkg::COORD_BITS-1:0]  cfg_data
);

  qmask_pkg::corner_arr_t corners;
  logic                   in_accept;
  logic                   s3_valid;
  qmask_pkg::sign_flags_t s3_flags;
  qmask_pkg::color_pair_t s3_colors;

  // The pipeline never holds off an item
  assign busy      = 1'b0;
  assign in_accept = start && !busy;

  qmask_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .corners   (corners)
  );

  qmask_cross u_cross (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_accept),
    .in_item   (in_data),
    .corners   (corners),
    .s3_valid  (s3_valid),
    .s3_flags  (s3_flags),
    .s3_colors (s3_colors)
  );

  qmask_select u_select (
    .clk       (clk),
    .rst_n     (rst_n),
    .s3_valid  (s3_valid),
    .s3_flags  (s3_flags),
    .s3_colors (s3_colors),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  // Every result strobe traces back to an accepted item
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_accept, 4))
    else $error("result without accepted item");
`endif

endmodule

[src/qmask_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmask_cfg
// Corner register file, written through the plain configuration port.
// ----------------------------------------------------------------------------
module qmask_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [qmask_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [qmask_pkg::COORD_BITS-1:0]   cfg_data,
  output qmask_pkg::corner_arr_t             corners
);

  qmask_pkg::corner_arr_t corners_r, corners_nxt;
  logic [qmask_pkg::CORNER_IDX_W-1:0] sel;

  assign sel = cfg_index[qmask_pkg::CFG_IDX_W-1:1];

  // Update the addressed coordinate
  always_comb begin
    corners_nxt = corners_r;
    if (cfg_we) begin
      unique case (cfg_index[0])
        qmask_pkg::AXIS_X: corners_nxt[sel].x = cfg_data;
        qmask_pkg::AXIS_Y: corners_nxt[sel].y = cfg_data;
        default:           corners_nxt = corners_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      corners_r <= '0;
    end else begin
      corners_r <= corners_nxt;
    end
  end

  assign corners = corners_r;

endmodule

[src/qmask_cross.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmask_cross
// Three-stage edge test: corner offsets, partial products, cross products
// reduced to sign flags.
// ----------------------------------------------------------------------------
module qmask_cross (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  qmask_pkg::in_item_t     in_item,
  input  qmask_pkg::corner_arr_t  corners,
  output logic                    s3_valid,
  output qmask_pkg::sign_flags_t  s3_flags,
  output qmask_pkg::color_pair_t  s3_colors
);

  localparam int DW = qmask_pkg::DIFF_W;
  localparam int PW = qmask_pkg::PROD_W;
  localparam int CW = qmask_pkg::CROSS_W;
  localparam int NC = qmask_pkg::NUM_CROSS;
  localparam int NK = qmask_pkg::NUM_CORNERS;
  localparam int IW = qmask_pkg::CORNER_IDX_W;

  // Stage 1: offsets of every corner from the pixel
  logic                   s1_valid_r;
  logic signed [DW-1:0]   dx_r [NK];
  logic signed [DW-1:0]   dy_r [NK];
  logic signed [DW-1:0]   dx_nxt [NK];
  logic signed [DW-1:0]   dy_nxt [NK];
  qmask_pkg::color_pair_t s1_colors_r, s1_colors_nxt;

  // Stage 2: the two products of each cross product
  logic                   s2_valid_r;
  logic signed [PW-1:0]   pa_r [NC];
  logic signed [PW-1:0]   pb_r [NC];
  logic signed [PW-1:0]   pa_nxt [NC];
  logic signed [PW-1:0]   pb_nxt [NC];
  qmask_pkg::color_pair_t s2_colors_r;

  // Stage 3: sign of each cross product
  logic                   s3_valid_r;
  qmask_pkg::sign_flags_t s3_flags_r, s3_flags_nxt;
  qmask_pkg::color_pair_t s3_colors_r;

  // Subtract the pixel from each corner
  always_comb begin
    for (int i = 0; i < NK; i++) begin
      dx_nxt[i] = $signed({1'b0, corners[i].x}) - $signed({1'b0, in_item.pixel_col});
      dy_nxt[i] = $signed({1'b0, corners[i].y}) - $signed({1'b0, in_item.pixel_row});
    end
    s1_colors_nxt.fore = '{blue: in_item.fore_blue, green: in_item.fore_green,
                           red: in_item.fore_red};
    s1_colors_nxt.back = '{blue: in_item.back_blue, green: in_item.back_green,
                           red: in_item.back_red};
  end

  // Form ax*by and bx*ay for each edge pair
  always_comb begin
    for (int k = 0; k < NC; k++) begin
      pa_nxt[k] = PW'(dx_r[IW'(qmask_pkg::CROSS_A[k])])
                * PW'(dy_r[IW'(qmask_pkg::CROSS_B[k])]);
      pb_nxt[k] = PW'(dx_r[IW'(qmask_pkg::CROSS_B[k])])
                * PW'(dy_r[IW'(qmask_pkg::CROSS_A[k])]);
    end
  end

  // Subtract and keep only the sign
  always_comb begin
    logic signed [CW-1:0] cr;
    cr = '0;
    s3_flags_nxt = '0;
    for (int k = 0; k < NC; k++) begin
      cr = CW'(pa_r[k]) - CW'(pb_r[k]);
      s3_flags_nxt.neg[k] = cr[CW-1];
      s3_flags_nxt.pos[k] = !cr[CW-1] && (cr != '0);
    end
  end

  // Advance valid bits every cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  // Advance payload every cycle
  always_ff @(posedge clk) begin
    dx_r        <= dx_nxt;
    dy_r        <= dy_nxt;
    s1_colors_r <= s1_colors_nxt;
    pa_r        <= pa_nxt;
    pb_r        <= pb_nxt;
    s2_colors_r <= s1_colors_r;
    s3_flags_r  <= s3_flags_nxt;
    s3_colors_r <= s2_colors_r;
  end

  assign s3_valid  = s3_valid_r;
  assign s3_flags  = s3_flags_r;
  assign s3_colors = s3_colors_r;

`ifndef NO_ASSERTIONS
  // A valid item at stage 3 traces back to a valid input item
  a_valid_chain: assert property (@(posedge clk) disable iff (!rst_n)
    s3_valid_r |-> $past(in_valid, 3))
    else $error("stage 3 valid without matching input");

  // A cross product is never both positive and negative
  a_sign_excl: assert property (@(posedge clk) disable iff (!rst_n)
    s3_valid_r |-> ((s3_flags_r.pos & s3_flags_r.neg) == '0))
    else $error("conflicting sign flags");
`endif

endmodule

[src/qmask_select.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmask_select
// Final stage: triangle containment from edge signs and color selection.
// ----------------------------------------------------------------------------
module qmask_select (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    s3_valid,
  input  qmask_pkg::sign_flags_t  s3_flags,
  input  qmask_pkg::color_pair_t  s3_colors,
  output logic                    out_valid,
  output qmask_pkg::out_item_t    out_data
);

  logic                 out_valid_r;
  qmask_pkg::out_item_t out_data_r, out_data_nxt;
  logic                 tri0_in, tri1_in, quad_hit;
  logic [2:0]           t0_pos, t0_neg, t1_pos, t1_neg;

  // Gather edge signs per triangle; edge c2->c0 runs reversed in the second
  assign t0_pos = {s3_flags.pos[qmask_pkg::CR_01], s3_flags.pos[qmask_pkg::CR_12],
                   s3_flags.pos[qmask_pkg::CR_20]};
  assign t0_neg = {s3_flags.neg[qmask_pkg::CR_01], s3_flags.neg[qmask_pkg::CR_12],
                   s3_flags.neg[qmask_pkg::CR_20]};
  assign t1_pos = {s3_flags.pos[qmask_pkg::CR_23], s3_flags.pos[qmask_pkg::CR_30],
                   s3_flags.neg[qmask_pkg::CR_20]};
  assign t1_neg = {s3_flags.neg[qmask_pkg::CR_23], s3_flags.neg[qmask_pkg::CR_30],
                   s3_flags.pos[qmask_pkg::CR_20]};

  // Sub-areas add up to the whole exactly when the edges do not disagree in sign
  assign tri0_in  = !((|t0_pos) && (|t0_neg));
  assign tri1_in  = !((|t1_pos) && (|t1_neg));
  assign quad_hit = tri0_in || tri1_in;

  // Pick foreground or background
  always_comb begin
    if (quad_hit) begin
      out_data_nxt = '{out_blue: s3_colors.fore.blue, out_green: s3_colors.fore.green,
                       out_red: s3_colors.fore.red, inside_quad: 1'b1};
    end else begin
      out_data_nxt = '{out_blue: s3_colors.back.blue, out_green: s3_colors.back.green,
                       out_red: s3_colors.back.red, inside_quad: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  // The strobe is the stage 3 valid, registered
  a_strobe_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (out_valid_r == $past(s3_valid)))
    else $error("result strobe out of step");

  // A pixel with no negative edge sign in the first triangle is inside
  a_tri0_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_valid && (t0_neg == '0)) |=> out_data_r.inside_quad)
    else $error("pixel on inner side of all edges marked outside");
`endif

endmodule
